// File: rtl/triangle_strip_to_list_assert.svh
// ----------------------------------------------------------------------------
// Triangle strip assembly assertion macros
// Concurrent check wrappers used by the strip assembly RTL.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_STRIP_TO_LIST_ASSERT_SVH
`define TRIANGLE_STRIP_TO_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSTL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("triangle strip assembly: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("triangle strip assembly: next-cycle check failed");

`endif

// File: rtl/tstl_pkg.sv
// ----------------------------------------------------------------------------
// Triangle strip assembly package
// Widths, result kinds and the result record of the strip assembler.
// ----------------------------------------------------------------------------
package tstl_pkg;

    localparam int INDEX_BITS     = 16;
    localparam int COUNT_BITS     = 24;
    localparam int IN_TDATA_BITS  = ((INDEX_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 * INDEX_BITS + 2 * COUNT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int KIND_BITS      = 2;

    typedef logic [INDEX_BITS-1:0]     t_index;
    typedef logic [COUNT_BITS-1:0]     t_count;
    typedef logic [IN_TDATA_BITS-1:0]  t_in_tdata;
    typedef logic [OUT_TDATA_BITS-1:0] t_out_tdata;

    localparam t_index VERTEX_COUNT_RESET = '1;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NONE  = 2'd0,
        KIND_TRI   = 2'd1,
        KIND_DEGEN = 2'd2,
        KIND_FAULT = 2'd3
    } t_kind;

    typedef struct packed {
        t_count drawable;
        t_count raw;
        t_index corner_c;
        t_index corner_b;
        t_index corner_a;
    } t_payload;

    typedef struct packed {
        t_kind    kind;
        t_payload payload;
    } t_result;

endpackage

// File: rtl/triangle_strip_to_list.sv
// ----------------------------------------------------------------------------
// Triangle strip to triangle list
// An input transfer's result is registered on the output, or in the skid if it stalls.
// Throughput: one index per cycle; the strip state updates at input transfer.
// A skid register takes one more result while the output stalls; input then holds.
// Reset clears the strip state, counters, fault and vertex count (to maximum).
// ----------------------------------------------------------------------------
module triangle_strip_to_list (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  tstl_pkg::t_index       i_cfg_wr_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  tstl_pkg::t_in_tdata    s_axis_tdata,   // [15:0] vertex_index
    input  logic                   s_axis_tuser,   // [0] strip_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output tstl_pkg::t_out_tdata   m_axis_tdata,   // corner_a, corner_b, corner_c,
                                                   // raw_triangles, drawable_triangles
    output logic [1:0]             m_axis_tuser    // [1:0] kind
);
    import tstl_pkg::*;

    t_index      r_vertex_count;
    t_index      r_older;
    t_index      r_newer;
    logic [1:0]  r_pos;
    logic        r_odd;
    logic        r_fault;
    t_count      r_raw_count;
    t_count      r_drawable_count;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    t_index      idx;
    logic        in_xfer;
    logic        out_load;
    logic        out_of_range;
    logic [1:0]  pos_eff;
    logic        odd_eff;
    t_index      corner_a;
    t_index      corner_b;
    logic        degenerate;
    t_count      raw_inc;
    t_count      drawable_inc;

    t_index      n_older;
    t_index      n_newer;
    logic [1:0]  n_pos;
    logic        n_odd;
    logic        n_fault;
    t_count      n_raw_count;
    t_count      n_drawable_count;
    t_result     n_result;

    assign idx           = s_axis_tdata[INDEX_BITS-1:0];
    assign s_axis_tready = i_rst_n && !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_load      = !r_out_valid || m_axis_tready;

    assign out_of_range  = (idx >= r_vertex_count);
    assign pos_eff       = s_axis_tuser ? 2'd0 : r_pos;
    assign odd_eff       = s_axis_tuser ? 1'b0 : r_odd;
    assign corner_a      = odd_eff ? r_newer : r_older;
    assign corner_b      = odd_eff ? r_older : r_newer;
    assign degenerate    = (corner_a == corner_b) || (corner_b == idx) || (corner_a == idx);
    assign raw_inc       = (&r_raw_count) ? r_raw_count : r_raw_count + 1'b1;
    assign drawable_inc  = (&r_drawable_count) ? r_drawable_count : r_drawable_count + 1'b1;

    always_comb begin
        n_older          = r_older;
        n_newer          = r_newer;
        n_pos            = r_pos;
        n_odd            = r_odd;
        n_fault          = r_fault;
        n_raw_count      = r_raw_count;
        n_drawable_count = r_drawable_count;
        n_result.kind    = KIND_FAULT;
        n_result.payload = '0;
        priority if (r_fault || out_of_range) begin
            n_fault = 1'b1;
        end else if (pos_eff != 2'd2) begin
            // open or extend the strip, no triangle yet
            n_older       = r_newer;
            n_newer       = idx;
            n_pos         = pos_eff + 2'd1;
            n_odd         = !odd_eff;
            n_result.kind = KIND_NONE;
        end else begin
            n_older     = r_newer;
            n_newer     = idx;
            n_pos       = pos_eff;
            n_odd       = !odd_eff;
            n_raw_count = raw_inc;
            if (!degenerate) begin
                n_drawable_count = drawable_inc;
            end
            n_result.kind             = degenerate ? KIND_DEGEN : KIND_TRI;
            n_result.payload.corner_a = corner_a;
            n_result.payload.corner_b = corner_b;
            n_result.payload.corner_c = idx;
        end
        n_result.payload.raw      = n_raw_count;
        n_result.payload.drawable = n_drawable_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count   <= VERTEX_COUNT_RESET;
            r_older          <= '0;
            r_newer          <= '0;
            r_pos            <= 2'd0;
            r_odd            <= 1'b0;
            r_fault          <= 1'b0;
            r_raw_count      <= '0;
            r_drawable_count <= '0;
            r_out_valid      <= 1'b0;
            r_skid_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_older          <= n_older;
                r_newer          <= n_newer;
                r_pos            <= n_pos;
                r_odd            <= n_odd;
                r_fault          <= n_fault;
                r_raw_count      <= n_raw_count;
                r_drawable_count <= n_drawable_count;
            end
            if (out_load) begin
                // drain the skid first; no input transfer while it is full
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_xfer;
                end
            end else if (in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (!out_load && in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = t_out_tdata'(r_out.payload);

`include "triangle_strip_to_list_assert.svh"

    `TSTL_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `TSTL_ASSERT_NEXT(a_fault_sticky, i_clk, i_rst_n, r_fault, r_fault)
    `TSTL_ASSERT_SAME(a_drawable_le_raw, i_clk, i_rst_n, 1'b1, r_drawable_count <= r_raw_count)
    `TSTL_ASSERT_SAME(a_fault_zero_corners, i_clk, i_rst_n,
        r_out_valid && (r_out.kind == KIND_FAULT || r_out.kind == KIND_NONE),
        r_out.payload.corner_a == '0 && r_out.payload.corner_c == '0)

endmodule
